>>> rtl/i2c_master_bit_sequencer_assert.svh
// ---------------------------------------------------------------------------
// I2C master bit sequencer assertion macros
// Shared concurrent assertion forms; they compile away under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define I2CMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c sequencer assertion failed");

// Next-cycle implication, checked out of reset.
`define I2CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c sequencer assertion failed");

`else

`define I2CMS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define I2CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/i2cms_pkg.sv
// ---------------------------------------------------------------------------
// I2C master bit sequencer package
// Command codes, shared structs and the per-phase line level decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_SACK  = 3'd5;
  localparam logic [2:0] OP_CACK  = 3'd6;

  localparam logic [15:0] PHASE_LEN_RESET = 16'd15;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       last;
  } phase_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic emit;
    logic advance;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic op_ok;
    logic timer_done;
    logic phase_last;
  } dp_status_t;

  // Line levels of one phase of a command, given the levels left behind
  // by the phase before it.
  function automatic phase_t phase_gen(
    input logic [2:0] op,
    input logic [4:0] step,
    input logic [7:0] tx,
    input logic       ack_bit,
    input logic [7:0] rx_bits,
    input logic       ack_line,
    input logic       scl_lvl,
    input logic       sda_lvl
  );
    phase_t p;
    p = '{scl: 1'b1, sda: 1'b1, rx_byte: 8'd0, ack_seen: 1'b0, last: 1'b0};
    case (op)
      OP_IDLE: begin
        p.scl  = (step == 5'd0) ? scl_lvl : 1'b1;
        p.last = (step == 5'd1);
      end
      OP_START: begin
        case (step)
          5'd0: p.scl = scl_lvl;
          5'd1: p.scl = 1'b1;
          5'd2: p.sda = 1'b0;
          default: begin
            p.scl  = 1'b0;
            p.sda  = 1'b0;
            p.last = 1'b1;
          end
        endcase
      end
      OP_STOP: begin
        case (step)
          5'd0: begin
            p.scl = scl_lvl;
            p.sda = 1'b0;
          end
          5'd1: p.sda = 1'b0;
          default: p.last = 1'b1;
        endcase
      end
      OP_WRITE: begin
        if (step < 5'd16) begin
          // Each bit takes a low and a high SCL phase, MSB first.
          p.sda = tx[3'd7 - step[3:1]];
          if (step[0]) begin
            p.scl = 1'b1;
          end else begin
            p.scl = (step == 5'd0) ? scl_lvl : 1'b0;
          end
        end else if (step == 5'd16) begin
          p.scl = 1'b0;
          p.sda = sda_lvl;
        end else begin
          p.scl  = 1'b0;
          p.last = 1'b1;
        end
      end
      OP_READ: begin
        if (step == 5'd0) begin
          p.scl = 1'b0;
          p.sda = sda_lvl;
        end else if (step == 5'd1) begin
          p.scl = 1'b0;
        end else begin
          p.scl = ~step[0];
        end
        if (step == 5'd17) begin
          p.last    = 1'b1;
          p.rx_byte = rx_bits;
        end
      end
      OP_SACK: begin
        case (step)
          5'd0: begin
            p.scl = 1'b0;
            p.sda = sda_lvl;
          end
          5'd1: begin
            p.scl = 1'b0;
            p.sda = ~ack_bit;
          end
          5'd2: p.sda = ~ack_bit;
          default: begin
            p.scl  = 1'b0;
            p.sda  = ~ack_bit;
            p.last = 1'b1;
          end
        endcase
      end
      OP_CACK: begin
        p.sda = sda_lvl;
        if (step != 5'd0) begin
          p.scl      = 1'b0;
          p.last     = 1'b1;
          p.ack_seen = ~ack_line;
        end
      end
      default: begin
        p.last = 1'b1;
      end
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> rtl/i2c_master_bit_sequencer.sv
// ---------------------------------------------------------------------------
// I2C master bit sequencer
// Turns bus commands into a stream of SCL/SDA phases, one result per phase.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake              Contents
//  in_      slave      in_tvalid/in_tready    one bus command
//  out_     master     out_tvalid/out_tready  one bus phase, tlast on the final one
//  cfg_     slave      cfg_valid/cfg_ready    phase_length write
//
//  A command has N phases (2 to 18). Each phase waits out the hold timer,
//  with a phase_length of 0 counted as 1, then sits in the output register
//  until it is taken.
//  One command is in flight at a time; a new one is taken once the final
//  phase is delivered. The unused operation code is taken and gives no
//  phase. Reset restores phase_length 15 and both lines released.
// ---------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_bit_sequencer_assert.svh"

module i2c_master_bit_sequencer
  import i2cms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // tx_byte[7:0], ack_to_send, rx_line_bits[7:0], ack_line
  input  wire logic [2:0]  in_tuser,  // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata, // scl_out, sda_out, rx_byte[7:0], ack_seen
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  phase_t     phase;

  assign cfg_ready = 1'b1;

  i2cms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  i2cms_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_op       (in_tuser),
    .in_tx       (in_tdata[7:0]),
    .in_ack_bit  (in_tdata[8]),
    .in_rx_bits  (in_tdata[16:9]),
    .in_ack_line (in_tdata[17]),
    .cfg_we      (cfg_valid),
    .cfg_value   (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .phase       (phase)
  );

  assign out_tdata = {5'd0, phase.ack_seen, phase.rx_byte, phase.sda, phase.scl};
  assign out_tlast = phase.last;

  // Input and output never overlap.
  `I2CMS_ASSERT_SAME(a_no_overlap, clk, rst_n, in_tready, !out_tvalid)
  // Delivering the final phase frees the block for the next command.
  `I2CMS_ASSERT_NEXT(a_last_frees, clk, rst_n, out_tvalid && out_tready && out_tlast, in_tready)
  // The unused code is dropped at once.
  `I2CMS_ASSERT_NEXT(a_bad_op_drop, clk, rst_n, in_tvalid && in_tready && in_tuser > OP_CACK, in_tready)
  // Read data and ack status only appear on the final phase.
  `I2CMS_ASSERT_SAME(a_status_last, clk, rst_n, out_tvalid && !out_tlast, out_tdata[10:2] == 9'd0)

endmodule

`default_nettype wire

>>> rtl/i2cms_ctrl.sv
// ---------------------------------------------------------------------------
// I2C master bit sequencer controller
// Sequences capture, phase hold and result hand-off for one command.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cms_ctrl
  import i2cms_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire dp_status_t status,
  output ctl_cmd_t        cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HOLD = 2'd1;
  localparam logic [1:0] ST_SHOW = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_SHOW);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        // The unused code is taken and dropped without any phase.
        if (in_tvalid && status.op_ok) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (status.timer_done) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_SHOW;
        end
      end
      ST_SHOW: begin
        if (out_tready) begin
          if (status.phase_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = ST_HOLD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/i2cms_dp.sv
// ---------------------------------------------------------------------------
// I2C master bit sequencer datapath
// Command registers, phase step and hold timer, line state and result.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cms_dp
  import i2cms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [2:0]  in_op,
  input  wire logic [7:0]  in_tx,
  input  wire logic        in_ack_bit,
  input  wire logic [7:0]  in_rx_bits,
  input  wire logic        in_ack_line,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_value,
  input  wire ctl_cmd_t    cmd,
  output dp_status_t       status,
  output phase_t           phase
);

  logic [2:0]  op_r;
  logic [7:0]  tx_r;
  logic        ack_bit_r;
  logic [7:0]  rx_bits_r;
  logic        ack_line_r;
  logic [4:0]  step_r;
  logic [15:0] timer_r;
  logic [15:0] phase_len_r;
  logic        scl_lvl_r;
  logic        sda_lvl_r;
  phase_t      out_r;
  phase_t      phase_nxt;
  logic [15:0] timer_load;

  // A zero length loads the timer as a length of one does.
  assign timer_load = (phase_len_r == 16'd0) ? 16'd0 : phase_len_r - 16'd1;

  assign phase_nxt = phase_gen(op_r, step_r, tx_r, ack_bit_r, rx_bits_r, ack_line_r,
                               scl_lvl_r, sda_lvl_r);

  assign status.op_ok      = (in_op <= OP_CACK);
  assign status.timer_done = (timer_r == 16'd0);
  assign status.phase_last = out_r.last;
  assign phase             = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_len_r <= PHASE_LEN_RESET;
      scl_lvl_r   <= 1'b1;
      sda_lvl_r   <= 1'b1;
    end else begin
      if (cfg_we) begin
        phase_len_r <= cfg_value;
      end
      if (cmd.emit) begin
        scl_lvl_r <= phase_nxt.scl;
        sda_lvl_r <= phase_nxt.sda;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_op;
      tx_r       <= in_tx;
      ack_bit_r  <= in_ack_bit;
      rx_bits_r  <= in_rx_bits;
      ack_line_r <= in_ack_line;
      step_r     <= 5'd0;
      timer_r    <= timer_load;
    end else if (cmd.advance) begin
      step_r  <= step_r + 5'd1;
      timer_r <= timer_load;
    end else if (timer_r != 16'd0) begin
      timer_r <= timer_r - 16'd1;
    end
    if (cmd.emit) begin
      out_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

>>> verif/i2c_master_bit_sequencer_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Sends bus commands with random gaps while the phase sink stalls at random.
// The expected SCL/SDA phase stream of every accepted command is predicted
// and each delivered phase is compared against it.
// ---------------------------------------------------------------------------
module i2c_master_bit_sequencer_test;
  import i2cms_pkg::*;

  localparam logic [2:0]  OP_UNUSED     = 3'd7;
  localparam int unsigned RANDOM_ITEMS  = 264;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       last;
  } bus_phase_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // tx_byte[7:0], ack_to_send, rx_line_bits[7:0], ack_line
  logic [2:0]  in_tuser;   // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // scl_out, sda_out, rx_byte[7:0], ack_seen
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  bus_phase_t  expected_phases[$];
  logic        line_scl = 1'b1;
  logic        line_sda = 1'b1;
  int unsigned phase_len_shadow = 32'(PHASE_LEN_RESET);
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;
  bit          no_gaps = 1'b0;

  i2c_master_bit_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Phase prediction
  // ---------------------------------------------------------------------
  task automatic add_phase(input logic scl, input logic sda);
    bus_phase_t ph;
    line_scl = scl;
    line_sda = sda;
    ph = '{scl: scl, sda: sda, rx_byte: 8'd0, ack_seen: 1'b0, last: 1'b0};
    expected_phases.push_back(ph);
  endtask

  task automatic close_command(input logic [7:0] rx, input logic ack);
    int unsigned idx;
    idx = expected_phases.size() - 1;
    expected_phases[idx].rx_byte  = rx;
    expected_phases[idx].ack_seen = ack;
    expected_phases[idx].last     = 1'b1;
  endtask

  task automatic predict_bus_phases(input logic [2:0] op, input logic [7:0] tx,
                                    input logic ack_bit, input logic [7:0] rx_bits,
                                    input logic ack_line);
    case (op)
      OP_IDLE: begin
        add_phase(line_scl, 1'b1);
        add_phase(1'b1, 1'b1);
        close_command(8'd0, 1'b0);
      end
      OP_START: begin
        add_phase(line_scl, 1'b1);
        add_phase(1'b1, 1'b1);
        add_phase(1'b1, 1'b0);
        add_phase(1'b0, 1'b0);
        close_command(8'd0, 1'b0);
      end
      OP_STOP: begin
        add_phase(line_scl, 1'b0);
        add_phase(1'b1, 1'b0);
        add_phase(1'b1, 1'b1);
        close_command(8'd0, 1'b0);
      end
      OP_WRITE: begin
        // Only the first bit starts from the SCL level left behind.
        for (int i = 7; i >= 0; i--) begin
          add_phase(line_scl, tx[i]);
          add_phase(1'b1, tx[i]);
          line_scl = 1'b0;
        end
        add_phase(1'b0, line_sda);
        add_phase(1'b0, 1'b1);
        close_command(8'd0, 1'b0);
      end
      OP_READ: begin
        add_phase(1'b0, line_sda);
        add_phase(1'b0, 1'b1);
        for (int i = 0; i < 8; i++) begin
          add_phase(1'b1, 1'b1);
          add_phase(1'b0, 1'b1);
        end
        close_command(rx_bits, 1'b0);
      end
      OP_SACK: begin
        add_phase(1'b0, line_sda);
        add_phase(1'b0, ~ack_bit);
        add_phase(1'b1, ~ack_bit);
        add_phase(1'b0, ~ack_bit);
        close_command(8'd0, 1'b0);
      end
      OP_CACK: begin
        add_phase(1'b1, line_sda);
        add_phase(1'b0, line_sda);
        close_command(8'd0, ~ack_line);
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: predicts on accepted commands, checks delivered phases and
  // ends the run when the bus goes quiet for far too long.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : bus_monitor
    bus_phase_t got;
    bus_phase_t want;
    bit         moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        phase_len_shadow = 32'(cfg_data);
        moved = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        predict_bus_phases(in_tuser, in_tdata[7:0], in_tdata[8], in_tdata[16:9],
                           in_tdata[17]);
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got = '{scl: out_tdata[0], sda: out_tdata[1], rx_byte: out_tdata[9:2],
                ack_seen: out_tdata[10], last: out_tlast};
        if (expected_phases.size() == 0) begin
          report_mismatch($sformatf("phase with nothing expected, got %p", got));
        end else begin
          want = expected_phases.pop_front();
          if (got.scl !== want.scl || got.sda !== want.sda ||
              got.rx_byte !== want.rx_byte || got.ack_seen !== want.ack_seen ||
              got.last !== want.last) begin
            report_mismatch($sformatf(
              "scl/sda/rx_byte/ack_seen/last expected %b/%b/%h/%b/%b got %b/%b/%h/%b/%b",
              want.scl, want.sda, want.rx_byte, want.ack_seen, want.last,
              got.scl, got.sda, got.rx_byte, got.ack_seen, got.last));
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      // A single phase at the longest hold, plus stalls, fits well inside this.
      if (quiet_cycles >= 4 * (phase_len_shadow + 1) + 200) begin
        $display("watchdog expired at %0t", $time);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Phase sink: a random stall before each transaction, none in burst stretches.
  initial begin : phase_sink
    int unsigned gap;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic send_command(input logic [2:0] op, input logic [7:0] tx,
                              input logic ack_bit, input logic [7:0] rx_bits,
                              input logic ack_line);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= {6'd0, ack_line, rx_bits, ack_bit, tx};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_random_fields(input logic [2:0] op);
    send_command(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Waits until every expected phase has been delivered and the block is idle.
  task automatic wait_bus_quiet();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_phases.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_phase_length(input logic [15:0] len);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_short_frame();
    send_random_fields(OP_START);
    send_random_fields(OP_WRITE);
    send_random_fields(OP_CACK);
    send_random_fields(OP_READ);
    send_random_fields(OP_SACK);
    send_random_fields(OP_STOP);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed_commands();
    send_command(OP_IDLE,  8'h00, 1'b0, 8'h00, 1'b0);
    send_command(OP_START, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_command(OP_WRITE, 8'hFF, 1'b0, 8'h00, 1'b0);
    send_command(OP_CACK,  8'h00, 1'b0, 8'h00, 1'b0);  // target acks
    send_command(OP_WRITE, 8'h00, 1'b1, 8'hFF, 1'b1);
    send_command(OP_CACK,  8'h00, 1'b0, 8'h00, 1'b1);  // target leaves SDA high
    send_command(OP_WRITE, 8'hA5, 1'b0, 8'h5A, 1'b0);
    send_command(OP_CACK,  8'hFF, 1'b1, 8'hFF, 1'b0);
    send_command(OP_READ,  8'hFF, 1'b0, 8'h00, 1'b1);
    send_command(OP_SACK,  8'h00, 1'b1, 8'h00, 1'b0);
    send_command(OP_READ,  8'h00, 1'b1, 8'hFF, 1'b0);
    send_command(OP_SACK,  8'hFF, 1'b0, 8'hFF, 1'b1);
    send_command(OP_READ,  8'h3C, 1'b0, 8'h5A, 1'b0);
    send_command(OP_SACK,  8'h00, 1'b1, 8'h00, 1'b0);
    send_command(OP_UNUSED, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_command(OP_STOP,  8'h00, 1'b0, 8'h00, 1'b0);
    send_command(OP_UNUSED, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(OP_IDLE,  8'h55, 1'b1, 8'hAA, 1'b1);
    send_command(OP_STOP,  8'h00, 1'b0, 8'h00, 1'b0);
    send_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
    send_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0);  // repeated start
    send_command(OP_CACK,  8'h00, 1'b0, 8'h00, 1'b1);
    send_command(OP_SACK,  8'h00, 1'b0, 8'h00, 1'b0);
    send_command(OP_STOP,  8'h00, 1'b0, 8'h00, 1'b0);
  endtask

  task automatic test_phase_length_extremes();
    wait_bus_quiet();
    write_phase_length(16'd0);  // zero is held as a length of one
    send_short_frame();
    wait_bus_quiet();
    write_phase_length(16'd1);
    send_short_frame();
    wait_bus_quiet();
    // The longest hold is expensive, so only a two-phase command runs with it.
    write_phase_length(16'hFFFF);
    send_random_fields(OP_CACK);
    wait_bus_quiet();
    write_phase_length(PHASE_LEN_RESET);
  endtask

  task automatic test_random_transactions();
    int unsigned target;
    int unsigned n_data;
    int unsigned n_noise;
    logic [7:0]  addr;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 5) == 0) begin
        wait_bus_quiet();
        write_phase_length(($urandom_range(0, 4) == 0) ? 16'd15 :
                           16'($urandom_range(0, 7)));
      end else if ($urandom_range(0, 7) == 0) begin
        wait_bus_quiet();
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        // Noise: arbitrary commands, the unused code included.
        n_noise = $urandom_range(1, 4);
        repeat (n_noise) send_random_fields(3'($urandom_range(0, 7)));
      end else begin
        // Well-formed transfer: address, then data in the direction it selects.
        addr = 8'($urandom_range(0, 255));
        send_random_fields(OP_START);
        send_command(OP_WRITE, addr, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
        send_random_fields(OP_CACK);
        n_data = $urandom_range(1, 4);
        for (int k = 0; k < n_data; k++) begin
          if (addr[0]) begin
            send_random_fields(OP_READ);
            send_command(OP_SACK, 8'($urandom_range(0, 255)), (k != n_data - 1),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          end else begin
            send_random_fields(OP_WRITE);
            send_random_fields(OP_CACK);
          end
        end
        if ($urandom_range(0, 5) == 0) send_random_fields(OP_IDLE);
        send_random_fields(OP_STOP);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin : run_tests
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_commands();
    test_phase_length_extremes();
    test_random_transactions();
    wait_bus_quiet();
    if (mismatch_count == 0 && expected_phases.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
